// ===== rtl/core/adsr_pkg.sv =====
// Package for the ADSR envelope counter: phase and action codes, state and
// configuration structs, the rate period table and the exponential divider table.
// No dependencies.
package adsr_pkg;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_RELEASE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_GATE_ON  = 3'd1,
        ACT_GATE_OFF = 3'd2,
        ACT_RESET    = 3'd3,
        ACT_LOAD     = 3'd4
    } action_t;

    localparam logic [1:0] CFG_ATTACK_RATE    = 2'd0;
    localparam logic [1:0] CFG_DECAY_RATE     = 2'd1;
    localparam logic [1:0] CFG_SUSTAIN_NIBBLE = 2'd2;
    localparam logic [1:0] CFG_RELEASE_RATE   = 2'd3;

    localparam logic [7:0]  ENV_MAX   = 8'hFF;
    localparam logic [14:0] RATE_ZERO = 15'd0;

    typedef struct packed {
        logic [3:0] attack_rate;
        logic [3:0] decay_rate;
        logic [3:0] sustain_nibble;
        logic [3:0] release_rate;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  env_cnt;
        logic [14:0] rate_cnt;
        logic [4:0]  exp_cnt;
        logic [4:0]  exp_per;
        logic        hold_zero;
    } env_state_t;

    localparam env_state_t STATE_RESET = '{
        phase:     PH_RELEASE,
        env_cnt:   8'd0,
        rate_cnt:  15'd0,
        exp_cnt:   5'd0,
        exp_per:   5'd1,
        hold_zero: 1'b1
    };

    function automatic logic [14:0] rate_period(input logic [3:0] sel);
        logic [14:0] p;
        case (sel)
            4'd0:    p = 15'd9;
            4'd1:    p = 15'd32;
            4'd2:    p = 15'd63;
            4'd3:    p = 15'd95;
            4'd4:    p = 15'd149;
            4'd5:    p = 15'd220;
            4'd6:    p = 15'd267;
            4'd7:    p = 15'd313;
            4'd8:    p = 15'd392;
            4'd9:    p = 15'd977;
            4'd10:   p = 15'd1954;
            4'd11:   p = 15'd3126;
            4'd12:   p = 15'd3907;
            4'd13:   p = 15'd11720;
            4'd14:   p = 15'd19532;
            default: p = 15'd31251;
        endcase
        return p;
    endfunction

    // The divider period changes only at a few breakpoints of the count.
    function automatic logic [4:0] exp_period_for(input logic [7:0] env,
                                                  input logic [4:0] cur);
        logic [4:0] p;
        case (env)
            8'hFF:   p = 5'd1;
            8'h5D:   p = 5'd2;
            8'h36:   p = 5'd4;
            8'h1A:   p = 5'd8;
            8'h0E:   p = 5'd16;
            8'h06:   p = 5'd30;
            8'h00:   p = 5'd1;
            default: p = cur;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/adsr_if.sv =====
// Handshake interfaces for the ADSR envelope counter: the input item channel
// and the result item channel. No dependencies.
interface adsr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] load_value;

    modport source (output valid, output action, output load_value, input ready);
    modport sink (input valid, input action, input load_value, output ready);
endinterface

interface adsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] env_level;
    logic [1:0] phase;
    logic       idle;

    modport source (output valid, output env_level, output phase, output idle,
                    input ready);
    modport sink (input valid, input env_level, input phase, input idle,
                  output ready);
endinterface

// ===== rtl/core/adsr_cfg_regs.sv =====
// Configuration register file of the ADSR envelope counter.
// Depends on adsr_pkg.
module adsr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [3:0]    cfg_data,
    output adsr_pkg::cfg_t cfg
);

    adsr_pkg::cfg_t cfg_reg;
    adsr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                adsr_pkg::CFG_ATTACK_RATE:    cfg_next.attack_rate    = cfg_data;
                adsr_pkg::CFG_DECAY_RATE:     cfg_next.decay_rate     = cfg_data;
                adsr_pkg::CFG_SUSTAIN_NIBBLE: cfg_next.sustain_nibble = cfg_data;
                adsr_pkg::CFG_RELEASE_RATE:   cfg_next.release_rate   = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/adsr_next_state.sv =====
// Combinational next-state logic of the ADSR envelope counter: applies one
// item to the current envelope state. Depends on adsr_pkg.
module adsr_next_state (
    input  adsr_pkg::env_state_t cur,
    input  adsr_pkg::cfg_t       cfg,
    input  logic [2:0]           action,
    input  logic [7:0]           load_value,
    output adsr_pkg::env_state_t nxt
);

    logic [3:0]  rate_sel;
    logic [14:0] rate_inc;
    logic        rate_hit;
    logic [7:0]  sustain_target;
    logic [7:0]  attack_env;
    logic [4:0]  fall_cnt;
    logic        fall_hit;
    logic [7:0]  fall_env;

    always_comb
    begin
        case (cur.phase)
            adsr_pkg::PH_ATTACK: rate_sel = cfg.attack_rate;
            adsr_pkg::PH_DECAY:  rate_sel = cfg.decay_rate;
            default:             rate_sel = cfg.release_rate;
        endcase
    end

    assign rate_inc       = cur.rate_cnt + 15'd1;
    assign rate_hit       = (rate_inc == adsr_pkg::rate_period(rate_sel));
    assign sustain_target = {cfg.sustain_nibble, cfg.sustain_nibble};
    assign attack_env     = (cur.env_cnt != adsr_pkg::ENV_MAX) ? cur.env_cnt + 8'd1
                                                               : cur.env_cnt;
    assign fall_cnt       = cur.exp_cnt + 5'd1;
    assign fall_hit       = (fall_cnt >= cur.exp_per);
    assign fall_env       = (cur.env_cnt != 8'd0) ? cur.env_cnt - 8'd1 : 8'd0;

    always_comb
    begin
        logic do_fall;
        do_fall = 1'b0;
        nxt     = cur;
        unique case (adsr_pkg::action_t'(action))
            adsr_pkg::ACT_TICK:
            begin
                if (!rate_hit)
                begin
                    nxt.rate_cnt = rate_inc;
                end
                else
                begin
                    nxt.rate_cnt = adsr_pkg::RATE_ZERO;
                    case (cur.phase)
                        adsr_pkg::PH_ATTACK:
                        begin
                            nxt.exp_cnt = 5'd0;
                            nxt.env_cnt = attack_env;
                            if (attack_env == adsr_pkg::ENV_MAX)
                            begin
                                nxt.phase   = adsr_pkg::PH_DECAY;
                                nxt.exp_per = 5'd1;
                            end
                        end
                        adsr_pkg::PH_DECAY:
                            do_fall = !cur.hold_zero && (cur.env_cnt != sustain_target);
                        default:
                            do_fall = !cur.hold_zero;
                    endcase
                end
            end
            adsr_pkg::ACT_GATE_ON:
            begin
                nxt.phase     = adsr_pkg::PH_ATTACK;
                nxt.hold_zero = 1'b0;
                nxt.exp_cnt   = 5'd0;
            end
            adsr_pkg::ACT_GATE_OFF: nxt.phase = adsr_pkg::PH_RELEASE;
            adsr_pkg::ACT_RESET:    nxt = adsr_pkg::STATE_RESET;
            adsr_pkg::ACT_LOAD:     nxt.env_cnt = load_value;
            default:                nxt = cur;
        endcase

        // One pass of the exponential divider for decay and release steps.
        if (do_fall)
        begin
            if (fall_hit)
            begin
                nxt.exp_cnt = 5'd0;
                nxt.env_cnt = fall_env;
                nxt.exp_per = adsr_pkg::exp_period_for(fall_env, cur.exp_per);
                if (fall_env == 8'd0)
                begin
                    nxt.hold_zero = 1'b1;
                end
            end
            else
            begin
                nxt.exp_cnt = fall_cnt;
            end
        end
    end

endmodule

// ===== rtl/core/adsr_envelope_counter.sv =====
// ADSR envelope counter top level. Throughput: one item per cycle while the
// result channel does not stall, set by the single pass from the input register
// through the next-state logic to the state and result registers. Reset: phase
// release, count zero, hold at zero set, divider period one, all configuration
// registers zero; no clearing pass.
module adsr_envelope_counter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [3:0]        cfg_data,
    adsr_in_if.sink           item_in,
    adsr_out_if.source        result_out
);

    adsr_pkg::cfg_t       cfg;
    adsr_pkg::env_state_t state_reg;
    adsr_pkg::env_state_t state_next;

    logic       in_valid_reg;
    logic [2:0] action_reg;
    logic [7:0] load_reg;
    logic       out_valid_reg;
    logic [7:0] env_out_reg;
    logic [1:0] phase_out_reg;
    logic       idle_out_reg;
    logic       advance;
    logic       in_take;
    logic       idle_next;

    adsr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_next_state u_next (
        .cur        (state_reg),
        .cfg        (cfg),
        .action     (action_reg),
        .load_value (load_reg),
        .nxt        (state_next)
    );

    // The held item moves on whenever the result register is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign in_take       = item_in.valid && item_in.ready;

    assign idle_next = (state_next.phase != adsr_pkg::PH_ATTACK)
                    && (state_next.phase != adsr_pkg::PH_DECAY)
                    && state_next.hold_zero && (state_next.env_cnt == 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= adsr_pkg::STATE_RESET;
        end
        else
        begin
            if (item_in.ready)
            begin
                in_valid_reg <= item_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= item_in.action;
            load_reg   <= item_in.load_value;
        end
        if (advance)
        begin
            env_out_reg   <= state_next.env_cnt;
            phase_out_reg <= state_next.phase;
            idle_out_reg  <= idle_next;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.env_level = env_out_reg;
    assign result_out.phase     = phase_out_reg;
    assign result_out.idle      = idle_out_reg;

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    a_state_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("envelope state changed without an item");

    a_attack_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == adsr_pkg::PH_ATTACK) |-> !state_reg.hold_zero)
        else $error("hold at zero set during attack");

    a_divider_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.exp_per != 5'd0)
        else $error("exponential divider period is zero");

    a_idle_in_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && idle_out_reg) |->
            (phase_out_reg == adsr_pkg::PH_RELEASE) && (env_out_reg == 8'd0))
        else $error("idle reported outside release at zero");

endmodule

// ===== dv/adsr_envelope_counter_checker.sv =====
// Checker for the ADSR envelope counter: tracks configuration writes, predicts the
// result of every accepted input item and compares it with the result channel.
// Depends on adsr_pkg and the adsr_in_if / adsr_out_if interfaces.
module adsr_envelope_counter_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    adsr_in_if         item_ch,
    adsr_out_if        result_ch,
    output int         pending,
    output int         mismatches
);

    typedef struct packed {
        logic [7:0] env_level;
        logic [1:0] phase;
        logic       idle;
    } envelope_result_t;

    localparam logic [14:0] STEP_PERIODS [16] = '{
        15'd9,   15'd32,   15'd63,   15'd95,   15'd149,   15'd220,   15'd267,   15'd313,
        15'd392, 15'd977,  15'd1954, 15'd3126, 15'd3907,  15'd11720, 15'd19532, 15'd31251
    };

    adsr_pkg::env_state_t envelope;
    adsr_pkg::cfg_t       settings;
    envelope_result_t     expected_levels [$];

    function automatic adsr_pkg::env_state_t next_envelope(input adsr_pkg::env_state_t s,
                                                           input adsr_pkg::cfg_t c,
                                                           input logic [2:0] act,
                                                           input logic [7:0] val);
        logic [3:0] sel;
        logic       falling;
        case (act)
            adsr_pkg::ACT_TICK:
            begin
                if (s.phase == adsr_pkg::PH_ATTACK)
                    sel = c.attack_rate;
                else if (s.phase == adsr_pkg::PH_DECAY)
                    sel = c.decay_rate;
                else
                    sel = c.release_rate;
                // The step counter is never cleared on a rate or phase change, so it
                // may have to wrap all the way around before the next match.
                s.rate_cnt = s.rate_cnt + 15'd1;
                if (s.rate_cnt == STEP_PERIODS[sel])
                begin
                    s.rate_cnt = '0;
                    if (s.phase == adsr_pkg::PH_ATTACK)
                    begin
                        s.exp_cnt = '0;
                        if (s.env_cnt != 8'hFF)
                            s.env_cnt = s.env_cnt + 8'd1;
                        if (s.env_cnt == 8'hFF)
                        begin
                            s.phase   = adsr_pkg::PH_DECAY;
                            s.exp_per = 5'd1;
                        end
                    end
                    else
                    begin
                        falling = !s.hold_zero && (s.phase != adsr_pkg::PH_DECAY ||
                                  s.env_cnt != {c.sustain_nibble, c.sustain_nibble});
                        if (falling)
                        begin
                            s.exp_cnt = s.exp_cnt + 5'd1;
                            if (s.exp_cnt >= s.exp_per)
                            begin
                                s.exp_cnt = '0;
                                if (s.env_cnt != 8'd0)
                                    s.env_cnt = s.env_cnt - 8'd1;
                                case (s.env_cnt)
                                    8'hFF, 8'h00: s.exp_per = 5'd1;
                                    8'h5D:        s.exp_per = 5'd2;
                                    8'h36:        s.exp_per = 5'd4;
                                    8'h1A:        s.exp_per = 5'd8;
                                    8'h0E:        s.exp_per = 5'd16;
                                    8'h06:        s.exp_per = 5'd30;
                                    default:      ;
                                endcase
                                if (s.env_cnt == 8'd0)
                                    s.hold_zero = 1'b1;
                            end
                        end
                    end
                end
            end
            adsr_pkg::ACT_GATE_ON:
            begin
                s.phase     = adsr_pkg::PH_ATTACK;
                s.hold_zero = 1'b0;
                s.exp_cnt   = '0;
            end
            adsr_pkg::ACT_GATE_OFF: s.phase = adsr_pkg::PH_RELEASE;
            adsr_pkg::ACT_RESET:    s = adsr_pkg::STATE_RESET;
            adsr_pkg::ACT_LOAD:     s.env_cnt = val;
            default:                ;
        endcase
        return s;
    endfunction

    task automatic count_failure(input string what);
        if (mismatches < 10)
            $display("[%0t] result mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        envelope_result_t want;
        envelope_result_t got;
        if (!rst_n)
        begin
            envelope   = adsr_pkg::STATE_RESET;
            settings   = '0;
            expected_levels.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    adsr_pkg::CFG_ATTACK_RATE:    settings.attack_rate    = cfg_data;
                    adsr_pkg::CFG_DECAY_RATE:     settings.decay_rate     = cfg_data;
                    adsr_pkg::CFG_SUSTAIN_NIBBLE: settings.sustain_nibble = cfg_data;
                    adsr_pkg::CFG_RELEASE_RATE:   settings.release_rate   = cfg_data;
                    default:                      ;
                endcase
            end

            // A result always belongs to an item accepted at an earlier edge.
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.env_level, result_ch.phase, result_ch.idle};
                if (expected_levels.size() == 0)
                    count_failure($sformatf("unexpected item level=%02h phase=%0d idle=%0b",
                                            got.env_level, got.phase, got.idle));
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.env_level !== want.env_level || got.phase !== want.phase ||
                        got.idle !== want.idle)
                        count_failure($sformatf(
                            {"expected level=%02h phase=%0d idle=%0b, ",
                             "got level=%02h phase=%0d idle=%0b"},
                            want.env_level, want.phase, want.idle,
                            got.env_level, got.phase, got.idle));
                end
            end

            if (item_ch.valid && item_ch.ready)
            begin
                envelope = next_envelope(envelope, settings, item_ch.action,
                                         item_ch.load_value);
                want.env_level = envelope.env_cnt;
                want.phase     = envelope.phase;
                want.idle      = envelope.phase != adsr_pkg::PH_ATTACK &&
                                 envelope.phase != adsr_pkg::PH_DECAY &&
                                 envelope.hold_zero && envelope.env_cnt == 8'd0;
                expected_levels.push_back(want);
            end
            pending = expected_levels.size();
        end
    end

endmodule

// ===== dv/adsr_envelope_counter_tb.sv =====
// Testbench top for the ADSR envelope counter: clock, reset, configuration writes,
// directed and random item stimulus with random gaps and stalls, and the verdict.
// Depends on adsr_pkg, the channel interfaces, the block and the checker.
module adsr_envelope_counter_tb;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int CYCLE_LIMIT = 800000;

    localparam logic [7:0] DIVIDER_POINTS [7] = '{
        8'hFF, 8'h5D, 8'h36, 8'h1A, 8'h0E, 8'h06, 8'h00
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;
    int         pending;
    int         mismatches;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         source_gaps = 1'b1;
    bit         sink_stalls = 1'b1;

    adsr_in_if  item_ch ();
    adsr_out_if result_ch ();

    adsr_envelope_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (item_ch),
        .result_out (result_ch)
    );

    adsr_envelope_counter_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_ch    (item_ch),
        .result_ch  (result_ch),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly no pause, sometimes a short one, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [3:0] pick_rate();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, 2));
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 2) == 0)
        begin
            stall_left = pause_len();
            result_ch.ready <= (stall_left == 0);
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic write_setting(input logic [1:0] idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input adsr_pkg::cfg_t s);
        write_setting(adsr_pkg::CFG_ATTACK_RATE, s.attack_rate);
        write_setting(adsr_pkg::CFG_DECAY_RATE, s.decay_rate);
        write_setting(adsr_pkg::CFG_SUSTAIN_NIBBLE, s.sustain_nibble);
        write_setting(adsr_pkg::CFG_RELEASE_RATE, s.release_rate);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic [2:0] act, input logic [7:0] val);
        int gap;
        gap = source_gaps ? pause_len() : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.load_value <= val;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        adsr_pkg::cfg_t setting;
        logic [2:0]     act;
        logic [7:0]     val;
        int             pick;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = adsr_pkg::CFG_ATTACK_RATE;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.action     = adsr_pkg::ACT_TICK;
        item_ch.load_value = '0;
        result_ch.ready    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: attack at the fastest rate, release at the next one up.
        setting = '{attack_rate: 4'd0, decay_rate: 4'd0, sustain_nibble: 4'd0,
                    release_rate: 4'd1};
        apply_settings(setting);
        send_item(adsr_pkg::ACT_TICK, 8'h00);
        for (int c = 5; c <= 7; c++)
            send_item(3'(c), 8'hA5);
        send_item(adsr_pkg::ACT_LOAD, 8'hFF);
        send_item(adsr_pkg::ACT_LOAD, 8'h00);
        send_item(adsr_pkg::ACT_GATE_ON, 8'h00);
        // One step short of full scale, so attack turns into decay.
        send_item(adsr_pkg::ACT_LOAD, 8'hFE);
        repeat (9) send_item(adsr_pkg::ACT_TICK, 8'hFF);
        send_item(adsr_pkg::ACT_GATE_OFF, 8'h00);
        // The step counter now passes the attack period: the gate-on below
        // leaves the envelope stuck until the counter wraps.
        repeat (8) send_item(adsr_pkg::ACT_TICK, 8'h00);
        send_item(adsr_pkg::ACT_GATE_ON, 8'h00);
        send_item(adsr_pkg::ACT_TICK, 8'h00);
        send_item(adsr_pkg::ACT_RESET, 8'h00);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                setting = '0;
            else if (p == 1)
                setting = '{attack_rate: 4'd15, decay_rate: 4'd0, sustain_nibble: 4'd15,
                            release_rate: 4'd15};
            else
                setting = '{attack_rate: pick_rate(), decay_rate: pick_rate(),
                            sustain_nibble: 4'($urandom_range(0, 15)),
                            release_rate: pick_rate()};
            apply_settings(setting);
            source_gaps = (p % 4 != 1);
            sink_stalls = (p % 4 != 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 199);
                if (pick < 168)
                    act = adsr_pkg::ACT_TICK;
                else if (pick < 176)
                    act = adsr_pkg::ACT_GATE_ON;
                else if (pick < 184)
                    act = adsr_pkg::ACT_GATE_OFF;
                else if (pick < 193)
                    act = adsr_pkg::ACT_LOAD;
                else if (pick < 196)
                    act = adsr_pkg::ACT_RESET;
                else
                    act = 3'($urandom_range(5, 7));
                val = 8'($urandom_range(0, 255));
                // Half of the loads land near a divider breakpoint or the sustain level, so
                // the slow phases cross them within a few dozen ticks.
                if (act == adsr_pkg::ACT_LOAD)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick == 2)
                        val = DIVIDER_POINTS[$urandom_range(0, 6)] +
                              8'($urandom_range(0, 4)) - 8'd2;
                    else if (pick == 3)
                        val = {setting.sustain_nibble, setting.sustain_nibble} +
                              8'($urandom_range(0, 2));
                end
                send_item(act, val);
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
